// File: design/pftr_pkg.sv
`default_nettype none

package pftr_pkg;

  localparam int unsigned GLYPH_BYTES = 6;
  localparam int unsigned MAX_WIDTH   = 8;
  localparam int unsigned GLYPH_ROWS  = 5;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_LIMIT = 8'd128;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_CHAR  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_INK    = 2'd0,
    CFG_PAPER  = 2'd1,
    CFG_OPAQUE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_START,
    CMD_CR,
    CMD_LF,
    CMD_DRAW
  } cmd_op_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WID,
    B_ROW,
    B_PIX,
    B_FIN
  } back_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  glyph_code;
    logic [2:0]  glyph_row;
    logic [7:0]  font_byte;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  char_code;
  } pftr_in_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  pixel_colour;
    logic        last_pixel;
  } pftr_out_t;

  typedef struct packed {
    cmd_op_e     op;
    logic [6:0]  code;
    logic [2:0]  row;
    logic [7:0]  font_byte;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ink;
    logic [7:0] paper;
    logic       opaque;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/proportional_font_text_renderer.sv
`default_nettype none

// Character generator for a proportional five-row bitmap font. Load font bytes,
// send a start word, then character words; each drawable character yields one
// pixel word per set glyph bit (and, in opaque mode, per clear bit and spacing
// column), with last_pixel marking its final word. Input words are classified
// and queued (four entries); dropped codes never enter the queue, and loads,
// starts, CR and LF are each executed straight from the idle state at the
// execution side. A drawn glyph fetches its width and then its first row through
// the single font memory read port, each row spends a B_ROW state on its row
// byte plus w+1 pixel steps (w the glyph width) at one per cycle unless the output
// stalls, and a B_FIN state closes the character. Pixel words leave through
// an output register, so the consumer may stall without losing data. The font
// memory has no reset; configuration must be written only while no character is
// in work, as the registers are always ready.
module proportional_font_text_renderer #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned LINE_PITCH  = 6,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire pftr_pkg::pftr_in_t  in_word_i,
  output logic                     empty,
  input  wire logic                pop,
  output pftr_pkg::pftr_out_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);
  import pftr_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_wcmd, q_rcmd;
  cfg_t       cfg;
  logic [7:0] ink_q, paper_q;
  logic       opaque_q;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign cfg.ink     = ink_q;
  assign cfg.paper   = paper_q;
  assign cfg.opaque  = opaque_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q    <= '0;
      paper_q  <= '0;
      opaque_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INK:    ink_q    <= cfg_data_i;
        CFG_PAPER:  paper_q  <= cfg_data_i;
        CFG_OPAQUE: opaque_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pftr_front #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .push      (push),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_wcmd)
  );

  pftr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  pftr_back #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .LINE_PITCH (LINE_PITCH),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

  a_queue_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_empty && !q_push) |=> q_empty)
    else $error("command appeared without a push");

  a_push_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (push && !full))
    else $error("queue written without an accepted input word");
`endif

endmodule

`default_nettype wire

// File: design/pftr_front.sv
`default_nettype none

module pftr_front #(
  parameter int unsigned GLYPH_COUNT = 128
) (
  input  wire logic              push,
  input  wire pftr_pkg::pftr_in_t in_word_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output pftr_pkg::cmd_t         q_cmd_o
);
  import pftr_pkg::*;

  logic keep;

  always_comb begin
    keep              = 1'b0;
    q_cmd_o.op        = CMD_LOAD;
    q_cmd_o.code      = in_word_i.glyph_code;
    q_cmd_o.row       = in_word_i.glyph_row;
    q_cmd_o.font_byte = in_word_i.font_byte;
    q_cmd_o.start_x   = in_word_i.start_x;
    q_cmd_o.start_y   = in_word_i.start_y;
    case (req_e'(in_word_i.req_type))
      REQ_LOAD: begin
        keep = (32'(in_word_i.glyph_code) < GLYPH_COUNT) &&
               (32'(in_word_i.glyph_row) < GLYPH_BYTES);
      end
      REQ_START: begin
        keep       = 1'b1;
        q_cmd_o.op = CMD_START;
      end
      REQ_CHAR: begin
        q_cmd_o.code = in_word_i.char_code[6:0];
        if (in_word_i.char_code >= CHAR_LIMIT) begin
          keep = 1'b0;
        end else if (in_word_i.char_code == CHAR_CR) begin
          keep       = 1'b1;
          q_cmd_o.op = CMD_CR;
        end else if (in_word_i.char_code == CHAR_LF) begin
          keep       = 1'b1;
          q_cmd_o.op = CMD_LF;
        end else begin
          keep       = 32'(in_word_i.char_code) < GLYPH_COUNT;
          q_cmd_o.op = CMD_DRAW;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push_o = push && !q_full_i && keep;

endmodule

`default_nettype wire

// File: design/pftr_queue.sv
`default_nettype none

module pftr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pftr_pkg::cmd_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output pftr_pkg::cmd_t      rdata_o,
  output logic                empty_o
);
  import pftr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: design/pftr_back.sv
`default_nettype none

module pftr_back #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned LINE_PITCH  = 6,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pftr_pkg::cfg_t     cfg_i,
  input  wire logic               q_empty_i,
  input  wire pftr_pkg::cmd_t     q_cmd_i,
  output logic                    q_pop_o,
  input  wire logic               out_pop_i,
  output logic                    out_empty_o,
  output pftr_pkg::pftr_out_t     out_word_o
);
  import pftr_pkg::*;

  localparam int unsigned DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [3:0]        width_q, width_d;
  logic [7:0]        bits_q, bits_d;
  logic [3:0]        dx_q, dx_d;
  logic [2:0]        r_q, r_d;
  logic [COORD_BITS-1:0] origin_q, origin_d, col_q, col_d, row_q, row_d;
  logic              hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;
  pftr_out_t         hold_q, hold_d, out_q, out_d;

  logic              in_glyph, bit_set, emit, out_free;
  logic [7:0]        colour;
  pftr_out_t         pix;

  assign out_empty_o = !out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_pop_i;
  assign waddr = ADDR_W'(11'(q_cmd_i.code) * 11'(GLYPH_BYTES) + 11'(q_cmd_i.row));

  always_comb begin
    in_glyph = dx_q < width_q;
    bit_set  = in_glyph && bits_q[3'(width_q - 4'd1 - dx_q)];
    emit     = bit_set || cfg_i.opaque;
    colour   = bit_set ? cfg_i.ink : cfg_i.paper;
    pix.pixel_x      = 12'(col_q + COORD_BITS'(dx_q));
    pix.pixel_y      = 12'(row_q + COORD_BITS'(r_q));
    pix.pixel_colour = colour;
    pix.last_pixel   = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    width_d      = width_q;
    bits_d       = bits_q;
    dx_d         = dx_q;
    r_d          = r_q;
    origin_d     = origin_q;
    col_d        = col_q;
    row_d        = row_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && !out_pop_i;
    out_d        = out_q;
    we           = 1'b0;
    re           = 1'b0;
    raddr        = base_q;
    q_pop_o      = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            CMD_LOAD: we = 1'b1;
            CMD_START: begin
              origin_d = COORD_BITS'(q_cmd_i.start_x);
              col_d    = COORD_BITS'(q_cmd_i.start_x);
              row_d    = COORD_BITS'(q_cmd_i.start_y);
            end
            CMD_CR: col_d = origin_q;
            CMD_LF: begin
              col_d = origin_q;
              row_d = row_q + COORD_BITS'(LINE_PITCH);
            end
            CMD_DRAW: begin
              re      = 1'b1;
              raddr   = ADDR_W'(11'(q_cmd_i.code) * 11'(GLYPH_BYTES));
              base_d  = raddr;
              state_d = B_WID;
            end
            default: ;
          endcase
        end
      end
      B_WID: begin
        width_d = (rd_q > 8'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : rd_q[3:0];
        re      = 1'b1;
        raddr   = base_q + ADDR_W'(1);
        r_d     = '0;
        state_d = B_ROW;
      end
      B_ROW: begin
        bits_d  = rd_q;
        dx_d    = '0;
        state_d = B_PIX;
      end
      B_PIX: begin
        if (!(emit && hold_valid_q && !out_free)) begin
          if (emit) begin
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_valid_d = 1'b1;
            end
            hold_d       = pix;
            hold_valid_d = 1'b1;
          end
          if (!in_glyph) begin
            if (32'(r_q) == GLYPH_ROWS - 1) begin
              state_d = B_FIN;
            end else begin
              r_d     = r_q + 3'd1;
              re      = 1'b1;
              raddr   = base_q + ADDR_W'(r_q) + ADDR_W'(2);
              state_d = B_ROW;
            end
          end else begin
            dx_d = dx_q + 4'd1;
          end
        end
      end
      B_FIN: begin
        if (!hold_valid_q || out_free) begin
          if (hold_valid_q) begin
            out_d            = hold_q;
            out_d.last_pixel = 1'b1;
            out_valid_d      = 1'b1;
            hold_valid_d     = 1'b0;
          end
          col_d   = col_q + COORD_BITS'(width_q) + COORD_BITS'(1);
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      origin_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      origin_q     <= origin_d;
      col_q        <= col_d;
      row_q        <= row_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    width_q <= width_d;
    bits_q  <= bits_d;
    dx_q    <= dx_d;
    r_q     <= r_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= q_cmd_i.font_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/proportional_font_text_renderer_checker.sv
`timescale 1ns / 1ps

module proportional_font_text_renderer_checker #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned LINE_PITCH  = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  pftr_pkg::pftr_in_t  in_word_i,
  input  logic                empty,
  input  logic                pop,
  input  pftr_pkg::pftr_out_t out_word_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output int unsigned         fail_count_o = 0,
  output int unsigned         pixels_due_o = 0
);
  import pftr_pkg::*;

  logic [7:0]  glyph_bytes [GLYPH_COUNT * GLYPH_BYTES];
  logic [11:0] origin_col = '0;
  logic [11:0] cursor_col = '0;
  logic [11:0] cursor_row = '0;
  logic [7:0]  ink_colour = '0;
  logic [7:0]  paper_colour = '0;
  logic        opaque = 1'b0;
  pftr_out_t   pending_pixels [$];

  function automatic void queue_pixel(logic [11:0] x, logic [11:0] y, logic [7:0] colour);
    pftr_out_t px;
    px.pixel_x      = x;
    px.pixel_y      = y;
    px.pixel_colour = colour;
    px.last_pixel   = 1'b0;
    pending_pixels.push_back(px);
  endfunction

  function automatic void render_word(pftr_in_t w);
    int unsigned base;
    int unsigned wid;
    int          r;
    int          dx;
    int          first;
    logic [7:0]  bits;
    logic [11:0] y;
    first = pending_pixels.size();
    case (w.req_type)
      REQ_LOAD: begin
        if (w.glyph_code < GLYPH_COUNT && w.glyph_row < GLYPH_BYTES)
          glyph_bytes[w.glyph_code * GLYPH_BYTES + w.glyph_row] = w.font_byte;
      end
      REQ_START: begin
        origin_col = w.start_x;
        cursor_col = w.start_x;
        cursor_row = w.start_y;
      end
      REQ_CHAR: begin
        if (w.char_code >= CHAR_LIMIT) begin
        end else if (w.char_code == CHAR_CR) begin
          cursor_col = origin_col;
        end else if (w.char_code == CHAR_LF) begin
          cursor_col = origin_col;
          cursor_row = cursor_row + 12'(LINE_PITCH);
        end else if (w.char_code < GLYPH_COUNT) begin
          base = w.char_code * GLYPH_BYTES;
          wid  = glyph_bytes[base];
          if (wid > MAX_WIDTH) wid = MAX_WIDTH;
          for (r = 0; r < GLYPH_ROWS; r++) begin
            bits = glyph_bytes[base + 1 + r];
            y    = cursor_row + 12'(r);
            for (dx = 0; dx < wid; dx++) begin
              if (bits[wid - 1 - dx]) queue_pixel(cursor_col + 12'(dx), y, ink_colour);
              else if (opaque) queue_pixel(cursor_col + 12'(dx), y, paper_colour);
            end
            // spacing column
            if (opaque) queue_pixel(cursor_col + 12'(wid), y, paper_colour);
          end
          if (pending_pixels.size() > first)
            pending_pixels[pending_pixels.size() - 1].last_pixel = 1'b1;
          cursor_col = cursor_col + 12'(wid + 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pftr_out_t due;
    if (!rst_ni) begin
      origin_col   = '0;
      cursor_col   = '0;
      cursor_row   = '0;
      ink_colour   = '0;
      paper_colour = '0;
      opaque       = 1'b0;
      pending_pixels.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel word with none expected: x=%0d y=%0d colour=%0d last=%0d",
                 out_word_i.pixel_x, out_word_i.pixel_y, out_word_i.pixel_colour,
                 out_word_i.last_pixel);
          fail_count_o = fail_count_o + 1;
        end else begin
          due = pending_pixels.pop_front();
          if (out_word_i.pixel_x !== due.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", due.pixel_x, out_word_i.pixel_x);
            fail_count_o = fail_count_o + 1;
          end
          if (out_word_i.pixel_y !== due.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", due.pixel_y, out_word_i.pixel_y);
            fail_count_o = fail_count_o + 1;
          end
          if (out_word_i.pixel_colour !== due.pixel_colour) begin
            $error("pixel_colour: expected %0d, got %0d", due.pixel_colour,
                   out_word_i.pixel_colour);
            fail_count_o = fail_count_o + 1;
          end
          if (out_word_i.last_pixel !== due.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", due.last_pixel,
                   out_word_i.last_pixel);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INK:    ink_colour = cfg_data_i;
          CFG_PAPER:  paper_colour = cfg_data_i;
          CFG_OPAQUE: opaque = cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (push && !full) render_word(in_word_i);
    end
    pixels_due_o = pending_pixels.size();
  end

endmodule

// File: tb/sv/proportional_font_text_renderer_test.sv
`timescale 1ns / 1ps

module proportional_font_text_renderer_test;
  import pftr_pkg::*;

  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam int unsigned RANDOM_WORDS   = 200;
  localparam int unsigned SETTLE_CYCLES  = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  pftr_in_t   in_word = '0;
  logic       empty;
  logic       pop = 1'b0;
  pftr_out_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pixels_due;
  int unsigned idle_cycles = 0;
  int unsigned words_sent = 0;
  bit          steady = 1'b0;
  logic [5:0]  glyph_rows_loaded [128] = '{default: '0};
  logic [6:0]  drawable [$];

  always #10 clk_i = ~clk_i;

  proportional_font_text_renderer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  proportional_font_text_renderer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_word_i    (in_word),
    .empty        (empty),
    .pop          (pop),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pixels_due_o (pixels_due)
  );

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : pop_driver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // unused fields carry random bits
  function automatic pftr_in_t make_word(logic [1:0] kind);
    logic [63:0] raw;
    pftr_in_t    w;
    raw = {$urandom, $urandom};
    w = raw[$bits(pftr_in_t)-1:0];
    w.req_type = kind;
    return w;
  endfunction

  function automatic logic [11:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 12'(4095 - $urandom_range(0, 20));
    return 12'($urandom);
  endfunction

  function automatic logic [7:0] rand_width();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'($urandom_range(1, 8));
    if (roll < 85) return 8'd0;
    return 8'($urandom_range(9, 255));
  endfunction

  task automatic send_word(pftr_in_t w);
    int unsigned gap;
    bit          was_ready;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    if (w.req_type == REQ_LOAD && w.glyph_row < GLYPH_BYTES) begin
      was_ready = &glyph_rows_loaded[w.glyph_code];
      glyph_rows_loaded[w.glyph_code][w.glyph_row] = 1'b1;
      if (!was_ready && &glyph_rows_loaded[w.glyph_code] &&
          w.glyph_code != CHAR_CR && w.glyph_code != CHAR_LF)
        drawable.push_back(w.glyph_code);
    end
    if (!(w.req_type == REQ_UNUSED ||
          (w.req_type == REQ_LOAD && w.glyph_row >= GLYPH_BYTES) ||
          (w.req_type == REQ_CHAR && w.char_code >= CHAR_LIMIT)))
      words_sent++;
  endtask

  task automatic load_byte(logic [6:0] code, logic [2:0] row, logic [7:0] value);
    pftr_in_t w;
    w = make_word(REQ_LOAD);
    w.glyph_code = code;
    w.glyph_row  = row;
    w.font_byte  = value;
    send_word(w);
  endtask

  task automatic load_glyph(logic [6:0] code, logic [7:0] wid, logic [39:0] rows);
    int r;
    load_byte(code, 3'd0, wid);
    for (r = 1; r <= GLYPH_ROWS; r++) load_byte(code, 3'(r), rows[8*(r-1) +: 8]);
  endtask

  task automatic start_at(logic [11:0] x, logic [11:0] y);
    pftr_in_t w;
    w = make_word(REQ_START);
    w.start_x = x;
    w.start_y = y;
    send_word(w);
  endtask

  task automatic put_char(logic [7:0] code);
    pftr_in_t w;
    w = make_word(REQ_CHAR);
    w.char_code = code;
    send_word(w);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every pixel word is out, then let the block go idle
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (pixels_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_sequence();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      load_glyph(7'($urandom), rand_width(), {$urandom, 8'($urandom)});
    end else if (pick < 22) begin
      start_at(rand_coord(), rand_coord());
    end else if (pick < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          put_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        else
          put_char(8'(drawable[$urandom_range(0, drawable.size() - 1)]));
      end
    end else if (pick < 88) begin
      // partial glyph update or stray byte
      load_byte(7'($urandom), 3'($urandom_range(0, 5)), 8'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: put_char(8'($urandom_range(128, 255)));
        1: load_byte(7'($urandom), 3'($urandom_range(6, 7)), 8'($urandom));
        default: send_word(make_word(REQ_UNUSED));
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    logic [7:0]  ink;
    logic [7:0]  paper;
    logic        opaque;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_INK, 8'hFF);
    write_reg(CFG_PAPER, 8'h00);
    write_reg(CFG_OPAQUE, 8'd1);

    // wide glyph is clamped, zero-width glyph still gets its spacing column
    load_glyph(7'd0, 8'hFF, {8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h81});
    load_glyph(7'd127, 8'd0, {8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00});
    start_at(12'hFFF, 12'hFFE);
    put_char(8'd0);
    put_char(8'd127);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    put_char(8'd0);
    put_char(8'hFF);
    put_char(CHAR_LIMIT);
    load_byte(7'd5, 3'd6, 8'hAA);
    load_byte(7'd5, 3'd7, 8'h55);
    send_word(make_word(REQ_UNUSED));
    start_at(12'd0, 12'd0);
    put_char(8'd0);
    wait_drained();

    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      case (phase)
        0: begin
          ink = 8'h00;
          paper = 8'hFF;
          opaque = 1'b0;
        end
        1: begin
          ink = 8'hFF;
          paper = 8'h00;
          opaque = 1'b1;
        end
        default: begin
          ink = 8'($urandom);
          paper = 8'($urandom);
          opaque = 1'($urandom);
        end
      endcase
      write_reg(CFG_INK, ink);
      write_reg(CFG_PAPER, paper);
      write_reg(CFG_OPAQUE, {7'd0, opaque});
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 12)) run_sequence();
      steady = 1'b0;
      wait_drained();
      phase++;
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
